[rtl/akey_pkg.sv]
// Shared types, key codes and decode tables for the ADC ladder key scanner.
// No dependencies; every other file in rtl/ imports this package.
package akey_pkg;

    localparam int unsigned SAMPLE_W = 6;
    localparam int unsigned KEY_W    = 4;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned DEB_W    = 8;
    localparam int unsigned BAND_W   = 3;
    localparam int unsigned MUX_W    = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Key codes as reported on key_event.
    localparam logic [KEY_W-1:0] KEY_NONE    = 4'd0;
    localparam logic [KEY_W-1:0] KEY_POWER   = 4'd1;
    localparam logic [KEY_W-1:0] KEY_UP      = 4'd2;
    localparam logic [KEY_W-1:0] KEY_DOWN    = 4'd3;
    localparam logic [KEY_W-1:0] KEY_MENU    = 4'd4;
    localparam logic [KEY_W-1:0] KEY_TVPIP   = 4'd5;
    localparam logic [KEY_W-1:0] KEY_VOLUP   = 4'd6;
    localparam logic [KEY_W-1:0] KEY_AUTO    = 4'd7;
    localparam logic [KEY_W-1:0] KEY_VOLDOWN = 4'd8;
    localparam logic [KEY_W-1:0] KEY_SELECT  = 4'd9;

    // ADC mux codes for the two ladder channels.
    localparam logic [MUX_W-1:0] MUX_CH0 = 2'd1;
    localparam logic [MUX_W-1:0] MUX_CH1 = 2'd2;

    // Hold counter saturation point and auto-repeat spacing.
    localparam logic [COUNT_W-1:0] HOLD_MAX    = 16'hFFFE;
    localparam logic [COUNT_W:0]   REPEAT_STEP = 17'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MENU_EN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLREP_EN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BURN_EN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP      = 3'd6;

    typedef struct packed {
        logic [DEB_W-1:0]   debounce_ticks;
        logic [COUNT_W-1:0] repeat_base_ticks;
        logic [COUNT_W-1:0] long_press_ticks;
        logic               menu_init_enable;
        logic               volume_repeat_enable;
        logic               burn_test_enable;
        logic               swap_channels;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic                power_pin_low;
        logic                power_is_on;
    } sample_t;

    typedef struct packed {
        logic [MUX_W-1:0] next_mux_code;
        logic             channel_done;
        logic             burn_test_pulse;
        logic             factory_init_pulse;
        logic             repeat_active;
        logic [KEY_W-1:0] key_event;
    } result_t;

    // Voltage band of the ladder from the upper four sample bits:
    // 0 is no key, 1 to 4 are the four keys of the channel.
    function automatic logic [BAND_W-1:0] band_of(input logic [3:0] level);
        logic [BAND_W-1:0] band;
        case (level)
            4'd0:    band = 3'd1;
            4'd2:    band = 3'd2;
            4'd3:    band = 3'd2;
            4'd4:    band = 3'd2;
            4'd6:    band = 3'd3;
            4'd7:    band = 3'd3;
            4'd8:    band = 3'd3;
            4'd11:   band = 3'd4;
            4'd12:   band = 3'd4;
            default: band = 3'd0;
        endcase
        return band;
    endfunction

    function automatic logic [KEY_W-1:0] key_ch1(input logic [BAND_W-1:0] band);
        logic [KEY_W-1:0] key;
        case (band)
            3'd1:    key = KEY_UP;
            3'd2:    key = KEY_DOWN;
            3'd3:    key = KEY_MENU;
            3'd4:    key = KEY_TVPIP;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

    function automatic logic [KEY_W-1:0] key_ch0(input logic [BAND_W-1:0] band);
        logic [KEY_W-1:0] key;
        case (band)
            3'd1:    key = KEY_VOLUP;
            3'd2:    key = KEY_AUTO;
            3'd3:    key = KEY_VOLDOWN;
            3'd4:    key = KEY_SELECT;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

[rtl/akey_cfg.sv]
// Configuration register file of the ADC ladder key scanner.
// Depends on akey_pkg for the register indexes and the cfg_t layout.
module akey_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [akey_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [akey_pkg::CFG_DATA_W-1:0]  cfg_data,
    output akey_pkg::cfg_t                   cfg
);
    import akey_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE:  cfg_next.debounce_ticks       = cfg_data[DEB_W-1:0];
                REG_REPEAT:    cfg_next.repeat_base_ticks    = cfg_data[COUNT_W-1:0];
                REG_LONG:      cfg_next.long_press_ticks     = cfg_data[COUNT_W-1:0];
                REG_MENU_EN:   cfg_next.menu_init_enable     = cfg_data[0];
                REG_VOLREP_EN: cfg_next.volume_repeat_enable = cfg_data[0];
                REG_BURN_EN:   cfg_next.burn_test_enable     = cfg_data[0];
                REG_SWAP:      cfg_next.swap_channels        = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks       <= 8'd10;
            cfg_reg.repeat_base_ticks    <= 16'd50;
            cfg_reg.long_press_ticks     <= 16'd500;
            cfg_reg.menu_init_enable     <= 1'b1;
            cfg_reg.volume_repeat_enable <= 1'b1;
            cfg_reg.burn_test_enable     <= 1'b1;
            cfg_reg.swap_channels        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/akey_core.sv]
// Per-tick key decode, debounce, auto-repeat and long-press logic with the
// per-channel hold state. Depends on akey_pkg.
module akey_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  akey_pkg::sample_t   sample,
    input  akey_pkg::cfg_t      cfg,
    output akey_pkg::result_t   result
);
    import akey_pkg::*;

    logic               toggle_reg,  toggle_next;
    logic [KEY_W-1:0]   last1_reg,   last1_next;
    logic [KEY_W-1:0]   last0_reg,   last0_next;
    logic [COUNT_W-1:0] hold1_reg,   hold1_next;
    logic [COUNT_W-1:0] hold0_reg,   hold0_next;
    logic               rflag_reg,   rflag_next;

    logic [BAND_W-1:0]  band;
    logic [COUNT_W:0]   rep_point;
    logic [COUNT_W:0]   deb_ext;
    logic [COUNT_W:0]   long_ext;
    logic [COUNT_W:0]   base_ext;
    logic [COUNT_W:0]   cnt;
    logic [KEY_W-1:0]   det;
    logic [KEY_W-1:0]   last_key;
    logic [KEY_W-1:0]   key_out;
    logic               init_pulse;
    logic               burn_pulse;

    assign band      = band_of(sample.adc_sample[SAMPLE_W-1 -: 4]);
    assign base_ext  = {1'b0, cfg.repeat_base_ticks};
    assign rep_point = base_ext + REPEAT_STEP;
    assign deb_ext   = {{(COUNT_W+1-DEB_W){1'b0}}, cfg.debounce_ticks};
    assign long_ext  = {1'b0, cfg.long_press_ticks};
    assign toggle_next = ~toggle_reg;

    always_comb
    begin
        last1_next = last1_reg;
        last0_next = last0_reg;
        hold1_next = hold1_reg;
        hold0_next = hold0_reg;
        rflag_next = rflag_reg;
        key_out    = KEY_NONE;
        init_pulse = 1'b0;
        burn_pulse = 1'b0;

        // Detected key for this tick's channel; power pin wins on channel 1.
        if (toggle_next)
        begin
            cnt      = {1'b0, hold1_reg};
            last_key = last1_reg;
            if (sample.power_pin_low)
            begin
                det = KEY_POWER;
            end
            else if (sample.power_is_on)
            begin
                det = key_ch1(band);
            end
            else
            begin
                det = KEY_NONE;
            end
        end
        else
        begin
            cnt      = {1'b0, hold0_reg};
            last_key = last0_reg;
            det      = sample.power_is_on ? key_ch0(band) : KEY_NONE;
        end

        if (det != last_key)
        begin
            cnt        = '0;
            rflag_next = 1'b0;
        end
        else if (det == KEY_NONE)
        begin
            cnt = '0;
        end
        else
        begin
            cnt = cnt + 17'd1;
            if (cnt == deb_ext)
            begin
                key_out = det;
            end
            if (toggle_next)
            begin
                if ((det == KEY_UP || det == KEY_DOWN) && cnt >= deb_ext)
                begin
                    if (cnt == rep_point)
                    begin
                        cnt        = base_ext;
                        key_out    = det;
                        rflag_next = 1'b1;
                    end
                end
                else if (det == KEY_MENU && cfg.menu_init_enable)
                begin
                    if (cnt >= long_ext && sample.power_is_on)
                    begin
                        cnt        = '0;
                        key_out    = KEY_POWER;
                        init_pulse = 1'b1;
                    end
                end
            end
            else
            begin
                if (cfg.volume_repeat_enable && (det == KEY_VOLDOWN || det == KEY_VOLUP)
                    && cnt == rep_point && cnt >= deb_ext)
                begin
                    cnt        = base_ext;
                    key_out    = det;
                    rflag_next = 1'b1;
                end
                if (cfg.burn_test_enable && det == KEY_SELECT && sample.power_is_on
                    && cnt >= long_ext)
                begin
                    cnt        = '0;
                    key_out    = KEY_NONE;
                    burn_pulse = 1'b1;
                end
            end
            if (cnt >= {1'b0, HOLD_MAX})
            begin
                cnt = {1'b0, HOLD_MAX};
            end
        end

        if (toggle_next)
        begin
            last1_next = det;
            hold1_next = cnt[COUNT_W-1:0];
        end
        else
        begin
            last0_next = det;
            hold0_next = cnt[COUNT_W-1:0];
        end

        result.key_event          = key_out;
        result.repeat_active      = rflag_next;
        result.factory_init_pulse = init_pulse;
        result.burn_test_pulse    = burn_pulse;
        result.channel_done       = toggle_next;
        if (toggle_next)
        begin
            result.next_mux_code = cfg.swap_channels ? MUX_CH0 : MUX_CH1;
        end
        else
        begin
            result.next_mux_code = cfg.swap_channels ? MUX_CH1 : MUX_CH0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg <= 1'b0;
            last1_reg  <= KEY_NONE;
            last0_reg  <= KEY_NONE;
            hold1_reg  <= '0;
            hold0_reg  <= '0;
            rflag_reg  <= 1'b0;
        end
        else if (fire)
        begin
            toggle_reg <= toggle_next;
            last1_reg  <= last1_next;
            last0_reg  <= last0_next;
            hold1_reg  <= hold1_next;
            hold0_reg  <= hold0_next;
            rflag_reg  <= rflag_next;
        end
    end

    // A factory-init request always comes with the power key on channel 1.
    a_init_power: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.factory_init_pulse |->
            result.key_event == KEY_POWER && result.channel_done)
        else $error("factory init without power key on channel 1");

    // A burn-test request suppresses the key report and belongs to channel 0.
    a_burn_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.burn_test_pulse |->
            result.key_event == KEY_NONE && !result.channel_done)
        else $error("burn test pulse with a key report or on channel 1");

    // Channels alternate on every processed tick.
    a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> toggle_reg != $past(toggle_reg))
        else $error("channel did not alternate");

    // Hold counters never pass the saturation point.
    a_hold_sat: assert property (@(posedge clk) disable iff (!rst_n)
        hold1_reg <= HOLD_MAX && hold0_reg <= HOLD_MAX)
        else $error("hold counter above saturation");

    // A key change on channel 1 clears that channel's hold count.
    a_change_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && toggle_next && last1_next != last1_reg |=> hold1_reg == '0)
        else $error("hold count not cleared on key change");

endmodule

[rtl/adc_ladder_key_scanner.sv]
// Top level of the two-channel ADC ladder key scanner: stream ports, input
// and result registers. Depends on akey_pkg, akey_cfg and akey_core.
//
// Usage:
// Each beat on the s_ group is one scan tick: the 6-bit conversion result of
// the channel sampled this tick plus the power pin and main-power status.
// Channel 1 is processed first after reset and the channel alternates on
// every beat; the m_ group returns exactly one result beat per input beat,
// carrying the key report, the repeat flag, the two long-press pulses, the
// channel that was processed and the mux code to start the next conversion.
// An accepted beat lands in the input register, and the decode, debounce
// and repeat logic then writes the result register. Throughput is one beat
// per cycle while the receiver keeps m_tready high; the per-channel hold
// counters are updated in the same cycle that the result register is loaded.
// When the receiver stalls, the result register holds its beat and the
// input register fills, after which s_tready drops; nothing is lost.
// The cfg_ write channel is always ready and should only be used while no
// beat is in flight. Reset empties both pipeline registers, clears the hold
// state of both channels and restores every configuration register to default.
module adc_ladder_key_scanner (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input beat, from the lowest bit: adc_sample[5:0], power_pin_low,
    // power_is_on.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    // Result beat, from the lowest bit: key_event[3:0], repeat_active,
    // factory_init_pulse, burn_test_pulse, channel_done,
    // next_mux_code[1:0], six zero bits.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [akey_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [akey_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import akey_pkg::*;

    cfg_t    cfg;
    sample_t in_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    fire;

    // The core runs when a tick waits and the result register is free or
    // being emptied this cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    akey_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    akey_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .sample (in_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.adc_sample    <= s_tdata[5:0];
            in_reg.power_pin_low <= s_tdata[6];
            in_reg.power_is_on   <= s_tdata[7];
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.next_mux_code, out_reg.channel_done,
                       out_reg.burn_test_pulse, out_reg.factory_init_pulse,
                       out_reg.repeat_active, out_reg.key_event};

endmodule
